@@ sv/fdem_pkg.sv @@
package fdem_pkg;

    // Default width of the entry position counter
    localparam int INDEX_BITS_DEF = 16;

    // Fixed field widths
    localparam int INDEX_W  = 16;
    localparam int MAX_TEXT = 12;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;

    // Directory entry markers and characters
    localparam logic [7:0] END_MARK       = 8'h00;
    localparam logic [7:0] DELETED_MARK   = 8'hE5;
    localparam logic [7:0] LONG_NAME_ATTR = 8'h0F;
    localparam int         DIR_BIT        = 4;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] DOT_CHAR       = 8'h2E;

    // Register indexes (byte address / 8)
    localparam logic [1:0] REG_HEAD   = 2'd0;
    localparam logic [1:0] REG_TAIL   = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_MISS  = 2'd0,
        ST_FOUND = 2'd1,
        ST_END   = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    // Target name as held in the configuration registers
    typedef struct packed {
        logic [63:0] head;
        logic [31:0] tail;
        logic [3:0]  length;
    } t_target;

    // Fold A-Z to lowercase
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Count base name bytes before the first space (0 to 8)
    function automatic logic [3:0] base_len(input logic [63:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (b[8*i +: 8] == SPACE_CHAR) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

    // Count extension bytes before the first space (0 to 3)
    function automatic logic [1:0] ext_len(input logic [23:0] e);
        logic [1:0] n;
        n = 2'd3;
        for (int i = 2; i >= 0; i--) begin
            if (e[8*i +: 8] == SPACE_CHAR) begin
                n = 2'(i);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/fat_directory_entry_matcher.sv @@
// An accepted item passes the input register, then the result register, before its result shows.
// One item per clock unless the output stalls; the name compare is a single pass of logic.
// A stall at the output holds both registers; the input stage still takes an item when empty.
// Reset (i_rst_n low at a clock edge) clears the target registers, the finished mark,
// the entry counter and both valid flags.
module fat_directory_entry_matcher #(
    parameter int INDEX_BITS = fdem_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdem_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdem_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdem_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_new_search,
    input  logic [63:0]                   i_base_name,
    input  logic [23:0]                   i_extension,
    input  logic [7:0]                    i_attributes,
    input  logic [15:0]                   i_cluster_upper,
    input  logic [15:0]                   i_cluster_lower,
    input  logic [31:0]                   i_size_bytes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_start_cluster,
    output logic [31:0]                   o_found_size,
    output logic                          o_is_directory,
    output logic [15:0]                   o_entry_index
);

    localparam int CNT_W = (INDEX_BITS < fdem_pkg::INDEX_W) ? INDEX_BITS : fdem_pkg::INDEX_W;

    fdem_pkg::t_target  target;
    logic               name_hit;

    // Input stage
    logic               r_s1_valid;
    logic               r_s1_new;
    logic [63:0]        r_s1_base;
    logic [23:0]        r_s1_ext;
    logic [7:0]         r_s1_attr;
    logic [31:0]        r_s1_cluster;
    logic [31:0]        r_s1_size;

    // Search state
    logic               r_fin;
    logic [CNT_W-1:0]   r_cnt;
    logic               n_fin;
    logic [CNT_W-1:0]   n_cnt;

    // Result stage
    logic               r_out_valid;
    fdem_pkg::t_status  r_out_status;
    logic [31:0]        r_out_cluster;
    logic [31:0]        r_out_size;
    logic               r_out_dir;
    logic [15:0]        r_out_index;
    fdem_pkg::t_status  n_status;
    logic [31:0]        n_cluster;
    logic [31:0]        n_size;
    logic               n_dir;

    logic               advance;
    logic               s2_fire;
    logic               fin_eff;
    logic [CNT_W-1:0]   cnt_eff;
    logic [7:0]         lead;

    fdem_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_target  (target)
    );

    assign pready = 1'b1;

    fdem_name_match u_match (
        .i_base_name (r_s1_base),
        .i_extension (r_s1_ext),
        .i_target    (target),
        .o_match     (name_hit)
    );

    // Handshake: the result register frees when empty or taken
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || advance;
    assign s2_fire = r_s1_valid && advance;

    // Capture an item into the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_new     <= i_new_search;
            r_s1_base    <= i_base_name;
            r_s1_ext     <= i_extension;
            r_s1_attr    <= i_attributes;
            r_s1_cluster <= {i_cluster_upper, i_cluster_lower};
            r_s1_size    <= i_size_bytes;
        end
    end

    // Classify the entry and work out the next search state
    assign fin_eff = r_s1_new ? 1'b0 : r_fin;
    assign cnt_eff = r_s1_new ? '0 : r_cnt;
    assign lead    = r_s1_base[7:0];

    always_comb begin
        n_fin     = fin_eff;
        n_cnt     = cnt_eff;
        n_status  = fdem_pkg::ST_MISS;
        n_cluster = '0;
        n_size    = '0;
        n_dir     = 1'b0;
        if (fin_eff) begin
            n_status = fdem_pkg::ST_DONE;
        end else begin
            if (cnt_eff != {CNT_W{1'b1}}) begin
                n_cnt = cnt_eff + CNT_W'(1);
            end
            if (lead == fdem_pkg::END_MARK) begin
                n_status = fdem_pkg::ST_END;
                n_fin    = 1'b1;
            end else if (lead == fdem_pkg::DELETED_MARK ||
                         r_s1_attr == fdem_pkg::LONG_NAME_ATTR) begin
                n_status = fdem_pkg::ST_MISS;
            end else if (name_hit) begin
                n_status  = fdem_pkg::ST_FOUND;
                n_fin     = 1'b1;
                n_cluster = r_s1_cluster;
                n_size    = r_s1_size;
                n_dir     = r_s1_attr[fdem_pkg::DIR_BIT];
            end
        end
    end

    // Update the search state once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else if (s2_fire) begin
            r_fin <= n_fin;
            r_cnt <= n_cnt;
        end
    end

    // Load the result register; drop valid when taken with nothing behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_status  <= n_status;
            r_out_cluster <= n_cluster;
            r_out_size    <= n_size;
            r_out_dir     <= n_dir;
            r_out_index   <= fdem_pkg::INDEX_W'(cnt_eff);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_start_cluster = r_out_cluster;
    assign o_found_size    = r_out_size;
    assign o_is_directory  = r_out_dir;
    assign o_entry_index   = r_out_index;

    // A found or end result finishes the search
    a_fin_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && (n_status == fdem_pkg::ST_FOUND || n_status == fdem_pkg::ST_END)
        |=> r_fin)
        else $error("search not marked finished after found or end");

    // Counter only moves up unless a new search starts
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && !r_s1_new |=> r_cnt >= $past(r_cnt))
        else $error("entry counter went backwards");

    // Only found results carry entry data
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != fdem_pkg::ST_FOUND
        |-> r_out_cluster == 32'd0 && r_out_size == 32'd0 && !r_out_dir)
        else $error("entry data on a result that is not found");

    // A held input item is never lost while the result stage stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_fire |=> r_s1_valid)
        else $error("input stage item dropped");

endmodule

@@ sv/fdem_cfg_regs.sv @@
module fdem_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [fdem_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [fdem_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [fdem_pkg::PDATA_W-1:0]  o_prdata,
    output fdem_pkg::t_target             o_target
);

    logic [1:0]         reg_sel;
    logic               wr_en;
    fdem_pkg::t_target  r_target;

    assign reg_sel = i_paddr[4:3];
    assign wr_en   = i_psel & i_penable & i_pwrite;

    // Write the selected register in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                fdem_pkg::REG_HEAD:   r_target.head   <= i_pwdata;
                fdem_pkg::REG_TAIL:   r_target.tail   <= i_pwdata[31:0];
                fdem_pkg::REG_LENGTH: r_target.length <= i_pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            fdem_pkg::REG_HEAD:   o_prdata = r_target.head;
            fdem_pkg::REG_TAIL:   o_prdata = {32'd0, r_target.tail};
            fdem_pkg::REG_LENGTH: o_prdata = {60'd0, r_target.length};
            default:              o_prdata = '0;
        endcase
    end

    assign o_target = r_target;

endmodule

@@ sv/fdem_name_match.sv @@
module fdem_name_match (
    input  logic [63:0]        i_base_name,
    input  logic [23:0]        i_extension,
    input  fdem_pkg::t_target  i_target,
    output logic               o_match
);

    localparam int NT = fdem_pkg::MAX_TEXT;

    logic [7:0]    base_b [8];
    logic [7:0]    ext_b  [3];
    logic [7:0]    tgt_b  [NT];
    logic [7:0]    text   [NT];
    logic [3:0]    blen;
    logic [1:0]    elen;
    logic          has_ext;
    logic [3:0]    tlen;
    logic [3:0]    off    [NT];
    logic [NT-1:0] eq;

    // Split the fields into bytes
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            base_b[i] = i_base_name[8*i +: 8];
            tgt_b[i]  = i_target.head[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            tgt_b[8+i] = i_target.tail[8*i +: 8];
        end
        for (int i = 0; i < 3; i++) begin
            ext_b[i] = i_extension[8*i +: 8];
        end
    end

    assign blen    = fdem_pkg::base_len(i_base_name);
    assign elen    = fdem_pkg::ext_len(i_extension);
    assign has_ext = (ext_b[0] != fdem_pkg::SPACE_CHAR);
    assign tlen    = has_ext ? (blen + 4'd1 + {2'd0, elen}) : blen;

    // Place each text character and compare it with the target
    always_comb begin
        for (int i = 0; i < NT; i++) begin
            off[i]  = 4'(i) - blen - 4'd1;
            text[i] = fdem_pkg::SPACE_CHAR;
            if (4'(i) < blen) begin
                text[i] = base_b[3'(i)];
            end else if (4'(i) == blen) begin
                text[i] = fdem_pkg::DOT_CHAR;
            end else if (off[i] < 4'd3) begin
                text[i] = ext_b[off[i][1:0]];
            end
            eq[i] = (4'(i) >= tlen) ||
                    (fdem_pkg::fold(text[i]) == fdem_pkg::fold(tgt_b[i]));
        end
    end

    // Lengths must agree; a length above twelve never agrees
    assign o_match = (tlen == i_target.length) && (&eq);

endmodule

@@ tb/sv/fat_directory_entry_matcher_checker.sv @@
module fat_directory_entry_matcher_checker #(
    parameter int INDEX_BITS = fdem_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdem_pkg::PADDR_W-1:0] paddr,
    input  logic [fdem_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         i_new_search,
    input  logic [63:0]                  i_base_name,
    input  logic [23:0]                  i_extension,
    input  logic [7:0]                   i_attributes,
    input  logic [15:0]                  i_cluster_upper,
    input  logic [15:0]                  i_cluster_lower,
    input  logic [31:0]                  i_size_bytes,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [1:0]                   o_status,
    input  logic [31:0]                  o_start_cluster,
    input  logic [31:0]                  o_found_size,
    input  logic                         o_is_directory,
    input  logic [15:0]                  o_entry_index,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Position counter stops at the smaller of its own range and 16 bits
    localparam longint INDEX_CAP = (INDEX_BITS >= 16) ? 64'd65535
                                                      : (longint'(1) << INDEX_BITS) - 1;

    typedef struct packed {
        fdem_pkg::t_status status;
        logic [31:0]       cluster;
        logic [31:0]       size;
        logic              is_dir;
        logic [15:0]       index;
    } t_lookup_result;

    logic [63:0]    tgt_head;
    logic [31:0]    tgt_tail;
    logic [3:0]     tgt_len;
    logic           search_done;
    logic [15:0]    entry_count;
    t_lookup_result expected_lookups[$];
    int             fail_count = 0;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c | 8'h20 : c;
    endfunction

    function automatic logic [7:0] target_byte(input int k);
        return (k < 8) ? tgt_head[8*k +: 8] : tgt_tail[8*(k-8) +: 8];
    endfunction

    // Rebuild the 8.3 text and compare it with the target, A-Z folded
    function automatic bit name_hit(input logic [63:0] base, input logic [23:0] ext);
        logic [7:0] txt [12];
        int         n;
        bit         stop;
        n = 0;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (base[8*k +: 8] == fdem_pkg::SPACE_CHAR) stop = 1'b1;
            if (!stop) begin
                txt[n] = base[8*k +: 8];
                n++;
            end
        end
        if (ext[7:0] != fdem_pkg::SPACE_CHAR) begin
            txt[n] = fdem_pkg::DOT_CHAR;
            n++;
            stop = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (ext[8*k +: 8] == fdem_pkg::SPACE_CHAR) stop = 1'b1;
                if (!stop) begin
                    txt[n] = ext[8*k +: 8];
                    n++;
                end
            end
        end
        if (tgt_len > fdem_pkg::MAX_TEXT || n != int'(tgt_len)) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (to_lower(txt[k]) != to_lower(target_byte(k))) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Classify one entry and advance the search state
    function automatic t_lookup_result classify_entry(input logic ns,
                                                      input logic [63:0] base,
                                                      input logic [23:0] ext,
                                                      input logic [7:0]  attr,
                                                      input logic [31:0] cluster,
                                                      input logic [31:0] size);
        t_lookup_result r;
        if (ns) begin
            search_done = 1'b0;
            entry_count = '0;
        end
        r = '0;
        r.status = fdem_pkg::ST_MISS;
        r.index = entry_count;
        if (search_done) begin
            r.status = fdem_pkg::ST_DONE;
            return r;
        end
        if (longint'(entry_count) < INDEX_CAP) entry_count = entry_count + 16'd1;
        if (base[7:0] == fdem_pkg::END_MARK) begin
            r.status = fdem_pkg::ST_END;
            search_done = 1'b1;
        end else if (base[7:0] == fdem_pkg::DELETED_MARK ||
                     attr == fdem_pkg::LONG_NAME_ATTR) begin
            r.status = fdem_pkg::ST_MISS;
        end else if (name_hit(base, ext)) begin
            r.status = fdem_pkg::ST_FOUND;
            r.cluster = cluster;
            r.size = size;
            r.is_dir = attr[fdem_pkg::DIR_BIT];
            search_done = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    task automatic check_result();
        t_lookup_result want;
        if (expected_lookups.size() == 0) begin
            fail_count++;
            $error("result item with no entry outstanding (status %0d)", o_status);
            return;
        end
        want = expected_lookups.pop_front();
        check_field("status", 32'(want.status), 32'(o_status));
        check_field("start_cluster", want.cluster, o_start_cluster);
        check_field("found_size", want.size, o_found_size);
        check_field("is_directory", 32'(want.is_dir), 32'(o_is_directory));
        check_field("entry_index", 32'(want.index), 32'(o_entry_index));
    endtask

    // Track register writes, compare results, then queue new predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tgt_head = '0;
            tgt_tail = '0;
            tgt_len = '0;
            search_done = 1'b0;
            entry_count = '0;
            expected_lookups.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[fdem_pkg::PADDR_W-1:3])
                    fdem_pkg::REG_HEAD:   tgt_head = pwdata[63:0];
                    fdem_pkg::REG_TAIL:   tgt_tail = pwdata[31:0];
                    fdem_pkg::REG_LENGTH: tgt_len = pwdata[3:0];
                    default:    ;
                endcase
            end
            if (o_valid && i_ready) check_result();
            if (i_valid && o_ready) begin
                expected_lookups.push_back(classify_entry(i_new_search, i_base_name,
                    i_extension, i_attributes, {i_cluster_upper, i_cluster_lower},
                    i_size_bytes));
            end
        end
        o_pending = expected_lookups.size();
        o_fail_count = fail_count;
    end

endmodule

@@ tb/sv/fat_directory_entry_matcher_tb.sv @@
module fat_directory_entry_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_BITS  = fdem_pkg::INDEX_BITS_DEF;
    localparam int ITEMS_TOTAL = 1150;
    localparam int BURST_ITEMS = 40;

    typedef struct packed {
        logic        new_search;
        logic [63:0] base;
        logic [23:0] ext;
        logic [7:0]  attr;
        logic [15:0] cl_hi;
        logic [15:0] cl_lo;
        logic [31:0] size;
    } t_dir_entry;

    // 8.3 name as it sits in an entry, plus the text the target register holds
    typedef struct packed {
        logic [63:0] base;
        logic [23:0] ext;
        logic [95:0] txt;
        logic [3:0]  len;
    } t_name;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fdem_pkg::PADDR_W-1:0]  paddr;
    logic [fdem_pkg::PDATA_W-1:0]  pwdata;
    logic [fdem_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_new_search;
    logic [63:0]                   i_base_name;
    logic [23:0]                   i_extension;
    logic [7:0]                    i_attributes;
    logic [15:0]                   i_cluster_upper;
    logic [15:0]                   i_cluster_lower;
    logic [31:0]                   i_size_bytes;
    logic                          o_valid;
    logic                          i_ready;
    logic [1:0]                    o_status;
    logic [31:0]                   o_start_cluster;
    logic [31:0]                   o_found_size;
    logic                          o_is_directory;
    logic [15:0]                   o_entry_index;

    int fail_count;
    int pending;
    int entries_sent = 0;
    int stall_left = 0;
    bit quiet_link = 1'b0;
    bit sink_open = 1'b0;

    always #2 i_clk = ~i_clk;

    fat_directory_entry_matcher #(
        .INDEX_BITS(INDEX_BITS)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_new_search(i_new_search),
        .i_base_name(i_base_name), .i_extension(i_extension),
        .i_attributes(i_attributes), .i_cluster_upper(i_cluster_upper),
        .i_cluster_lower(i_cluster_lower), .i_size_bytes(i_size_bytes),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_start_cluster(o_start_cluster), .o_found_size(o_found_size),
        .o_is_directory(o_is_directory), .o_entry_index(o_entry_index)
    );

    fat_directory_entry_matcher_checker #(
        .INDEX_BITS(INDEX_BITS)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_new_search(i_new_search),
        .i_base_name(i_base_name), .i_extension(i_extension),
        .i_attributes(i_attributes), .i_cluster_upper(i_cluster_upper),
        .i_cluster_lower(i_cluster_lower), .i_size_bytes(i_size_bytes),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_start_cluster(o_start_cluster), .o_found_size(o_found_size),
        .o_is_directory(o_is_directory), .o_entry_index(o_entry_index),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, a few long ones, none on a quiet link
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_link || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side now and then
    always @(negedge i_clk) begin
        if (sink_open || stall_left == 0) begin
            i_ready <= 1'b1;
            if (!sink_open && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end else begin
            i_ready <= 1'b0;
            stall_left--;
        end
    end

    function automatic logic [63:0] ascii8(input string s);
        logic [63:0] t;
        t = {8{fdem_pkg::SPACE_CHAR}};
        for (int k = 0; k < s.len() && k < 8; k++) t[8*k +: 8] = s[k];
        return t;
    endfunction

    function automatic logic [95:0] text96(input string s);
        logic [95:0] t;
        t = '0;
        for (int k = 0; k < s.len() && k < 12; k++) t[8*k +: 8] = s[k];
        return t;
    endfunction

    function automatic t_dir_entry rand_entry();
        t_dir_entry e;
        e.new_search = 1'b0;
        e.base = {$urandom, $urandom};
        e.ext = 24'($urandom);
        e.attr = 8'($urandom);
        e.cl_hi = 16'($urandom);
        e.cl_lo = 16'($urandom);
        e.size = $urandom;
        return e;
    endfunction

    function automatic t_dir_entry mk_entry(input logic ns, input logic [63:0] b,
                                            input logic [23:0] x, input logic [7:0] a);
        t_dir_entry e;
        e = rand_entry();
        e.new_search = ns;
        e.base = b;
        e.ext = x;
        e.attr = a;
        return e;
    endfunction

    // Name characters: letters of both cases, digits, fold edges, zero, deleted mark, other bytes
    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'h41 + 8'($urandom_range(0, 25));
        if (r < 60) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 72) return 8'h30 + 8'($urandom_range(0, 9));
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 8'h40;
                1: return 8'h5B;
                2: return 8'h60;
                default: return 8'h7B;
            endcase
        end
        if (r < 85) return fdem_pkg::END_MARK;
        if (r < 88) return fdem_pkg::DELETED_MARK;
        c = 8'($urandom);
        return (c == fdem_pkg::SPACE_CHAR) ? 8'h7E : c;
    endfunction

    function automatic t_name gen_name();
        t_name      nm;
        int         bl, xl, n;
        logic [7:0] c;
        nm.base = {8{fdem_pkg::SPACE_CHAR}};
        nm.ext = {3{fdem_pkg::SPACE_CHAR}};
        nm.txt = {$urandom, $urandom, $urandom};
        bl = $urandom_range(0, 8);
        xl = $urandom_range(0, 3);
        n = 0;
        for (int k = 0; k < bl; k++) begin
            c = pick_char();
            // keep the lead byte an ordinary character
            if (k == 0 && (c == fdem_pkg::END_MARK || c == fdem_pkg::DELETED_MARK)) c = 8'h58;
            nm.base[8*k +: 8] = c;
            nm.txt[8*n +: 8] = c;
            n++;
        end
        if (xl > 0) begin
            nm.txt[8*n +: 8] = fdem_pkg::DOT_CHAR;
            n++;
            for (int k = 0; k < xl; k++) begin
                c = pick_char();
                nm.ext[8*k +: 8] = c;
                nm.txt[8*n +: 8] = c;
                n++;
            end
        end
        nm.len = 4'(n);
        return nm;
    endfunction

    function automatic logic [63:0] shuffle_case(input logic [63:0] b);
        logic [63:0] r;
        logic [7:0]  c;
        r = b;
        for (int k = 0; k < 8; k++) begin
            c = b[8*k +: 8];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) == 1)
                r[8*k +: 8] = c ^ 8'h20;
        end
        return r;
    endfunction

    // One entry of a directory scan against the loaded name
    function automatic t_dir_entry scan_entry(input t_name nm);
        t_dir_entry e;
        int         r, p;
        e = rand_entry();
        r = $urandom_range(0, 99);
        if (r < 72) begin
            e.base = shuffle_case(nm.base);
            e.ext = 24'(shuffle_case({40'h0, nm.ext}));
        end
        if (r < 8) begin
            e.base[7:0] = fdem_pkg::DELETED_MARK;
        end else if (r < 16) begin
            e.attr = fdem_pkg::LONG_NAME_ATTR;
        end else if (r < 40) begin
            if (e.attr == fdem_pkg::LONG_NAME_ATTR) e.attr = 8'h10;
        end else if (r < 62) begin
            p = $urandom_range(0, 10);
            if (p < 8) e.base[8*p +: 8] = 8'($urandom);
            else e.ext[8*(p-8) +: 8] = 8'($urandom);
        end else if (r < 72) begin
            e.base[7:0] = fdem_pkg::END_MARK;
        end
        return e;
    endfunction

    // Present one item and hold it until taken; call on a falling edge
    task automatic send_entry(input t_dir_entry e);
        int gap;
        gap = pick_gap();
        i_valid <= 1'b1;
        i_new_search <= e.new_search;
        i_base_name <= e.base;
        i_extension <= e.ext;
        i_attributes <= e.attr;
        i_cluster_upper <= e.cl_hi;
        i_cluster_lower <= e.cl_lo;
        i_size_bytes <= e.size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        entries_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_target(input logic [95:0] txt, input logic [3:0] len);
        wait_idle();
        write_reg(fdem_pkg::REG_HEAD, txt[63:0]);
        write_reg(fdem_pkg::REG_TAIL, {32'h0, txt[95:64]});
        write_reg(fdem_pkg::REG_LENGTH, {60'h0, len});
    endtask

    initial begin
        t_dir_entry  e;
        t_name       nm;
        logic [95:0] t;
        logic [3:0]  tlen;
        int          n;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_new_search = 1'b0;
        i_base_name = '0;
        i_extension = '0;
        i_attributes = '0;
        i_cluster_upper = '0;
        i_cluster_lower = '0;
        i_size_bytes = '0;
        i_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset target is the empty name: a blank entry matches
        send_entry(mk_entry(1'b1, ascii8(""), 24'(ascii8("")), 8'h00));

        // Plain lookup: skips, hit as directory, finished search, mixed case, near misses, end mark
        load_target(text96("README.TXT"), 4'd10);
        send_entry(mk_entry(1'b1, ascii8("DATA"), 24'(ascii8("BIN")), 8'h20));
        e = mk_entry(1'b0, ascii8("README"), 24'(ascii8("TXT")), 8'h20);
        e.base[7:0] = fdem_pkg::DELETED_MARK;
        send_entry(e);
        send_entry(mk_entry(1'b0, ascii8("README"), 24'(ascii8("TXT")),
                            fdem_pkg::LONG_NAME_ATTR));
        e = mk_entry(1'b0, ascii8("README"), 24'(ascii8("TXT")), 8'h10);
        e.cl_hi = 16'hFFFF;
        e.cl_lo = 16'hFFFF;
        e.size = 32'hFFFF_FFFF;
        send_entry(e);
        send_entry(mk_entry(1'b0, ascii8("OTHER"), 24'(ascii8("TXT")), 8'h00));
        e = mk_entry(1'b1, ascii8("ReadMe"), 24'(ascii8("tXt")), 8'hEF);
        e.cl_hi = '0;
        e.cl_lo = '0;
        e.size = '0;
        send_entry(e);
        send_entry(mk_entry(1'b1, ascii8("README"), 24'(ascii8("TX")), 8'h01));
        send_entry(mk_entry(1'b0, ascii8("README"), 24'(ascii8(" TX")), 8'h01));
        e = mk_entry(1'b0, ascii8("README"), 24'(ascii8("TXT")), 8'h00);
        e.base[7:0] = fdem_pkg::END_MARK;
        send_entry(e);
        send_entry(mk_entry(1'b0, ascii8("README"), 24'(ascii8("TXT")), 8'h00));

        // Full twelve characters, then lengths past the limit
        load_target(text96("ABCDEFGH.IJK"), 4'd12);
        send_entry(mk_entry(1'b1, ascii8("ABCDEFGH"), 24'(ascii8("IJL")), 8'h00));
        send_entry(mk_entry(1'b0, ascii8("abcdefgh"), 24'(ascii8("ijk")), 8'h00));
        load_target(text96("ABCDEFGH.IJK"), 4'd13);
        send_entry(mk_entry(1'b1, ascii8("ABCDEFGH"), 24'(ascii8("IJK")), 8'h00));
        load_target(text96("ABCDEFGH.IJK"), 4'd15);
        send_entry(mk_entry(1'b1, ascii8("ABCDEFGH"), 24'(ascii8("IJK")), 8'h00));

        // Case folding only covers A-Z, not the neighbors
        load_target(text96("A@Z["), 4'd4);
        send_entry(mk_entry(1'b1, ascii8("a@z["), 24'(ascii8("")), 8'h00));
        e = mk_entry(1'b1, ascii8("A@Z["), 24'(ascii8("")), 8'h00);
        e.base[15:8] = 8'h60;
        e.base[31:24] = 8'h7B;
        send_entry(e);

        // All-ones target and name bytes
        load_target({96{1'b1}}, 4'd8);
        send_entry(mk_entry(1'b1, {64{1'b1}}, 24'(ascii8("")), 8'h00));

        // A zero byte inside the name is an ordinary character
        t = '0;
        t[7:0] = 8'h41;
        t[23:16] = 8'h62;
        load_target(t, 4'd3);
        e = mk_entry(1'b1, ascii8("a B"), 24'(ascii8("")), 8'h00);
        e.base[15:8] = 8'h00;
        send_entry(e);

        // Empty target: blank name hits, a bare extension does not
        load_target('0, 4'd0);
        send_entry(mk_entry(1'b1, ascii8(""), 24'(ascii8("")), 8'h00));
        send_entry(mk_entry(1'b1, ascii8(""), 24'(ascii8("X")), 8'h00));

        // Random scans, each target loaded once the link has drained
        while (entries_sent < ITEMS_TOTAL) begin
            nm = gen_name();
            tlen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15)) : nm.len;
            load_target(nm.txt, tlen);
            quiet_link = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) begin
                n = $urandom_range(1, 25);
                for (int k = 0; k < n; k++) begin
                    e = scan_entry(nm);
                    e.new_search = (k == 0 && $urandom_range(0, 9) != 0)
                                   || $urandom_range(0, 39) == 0;
                    send_entry(e);
                end
            end
        end

        // Stream a burst with no gaps on either side, then end the directory
        load_target('0, 4'd15);
        quiet_link = 1'b1;
        sink_open = 1'b1;
        for (int k = 0; k < BURST_ITEMS; k++) begin
            e = rand_entry();
            e.new_search = (k == 0);
            if (e.base[7:0] == fdem_pkg::END_MARK) e.base[7:0] = 8'h41;
            send_entry(e);
        end
        e = rand_entry();
        e.base[7:0] = fdem_pkg::END_MARK;
        send_entry(e);
        send_entry(rand_entry());
        quiet_link = 1'b0;
        sink_open = 1'b0;

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
